### sv/dts_pkg.sv
// Shared types and constants for the delimited token splitter.
package dts_pkg;

  localparam int MAX_LEN_DEF   = 65536;
  localparam int MAX_DELIM_DEF = 8;
  localparam int OFS_W         = 17;
  localparam int QUEUE_DEPTH   = 4;
  localparam int CFG_IDX_W     = 8;
  localparam int CFG_DATA_W    = 64;

  localparam logic [CFG_IDX_W-1:0] REG_DELIM_BYTES  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_LENGTH = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_EMPTY   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET = CFG_IDX_W'(3);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [OFS_W-1:0] token_start;
    logic [OFS_W-1:0] token_end;
    logic             has_token;
    logic             too_long;
    logic             end_of_string;
  } out_item_t;

  typedef struct packed {
    logic [63:0] delimiter_bytes;
    logic [3:0]  delimiter_length;
    logic        keep_empty;
    logic [15:0] start_offset;
  } cfg_t;

  // Results caused by one byte: an optional closed token, then an optional end marker.
  typedef struct packed {
    logic      has_match;
    out_item_t match_res;
    logic      has_final;
    out_item_t final_res;
  } res_pair_t;

endpackage

### sv/delimited_token_splitter.sv
// Top level of the delimited token splitter.
// Splits each byte string into tokens at leftmost non-overlapping matches of a 1 to 8 byte
// delimiter and reports token offsets, ending every string with an end_of_string result.
// Bytes are taken one per clock while in_stall is low; the front end compares the delimiter
// against its shift window combinationally. Results leave one per clock through a
// registered output unless out_stall holds it; a byte whose delimiter match also ends
// the string yields two results, sent one after the other. A four-entry queue separates
// the byte intake from the output, and in_stall rises only while that queue is full.
// Configuration writes are always ready and are meant for idle periods between strings.
module delimited_token_splitter import dts_pkg::*; #(
  parameter int MAX_LEN   = MAX_LEN_DEF,
  parameter int MAX_DELIM = MAX_DELIM_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t      cfg;
  logic      accept;
  logic      push;
  res_pair_t entry;
  res_pair_t head;
  logic      empty;
  logic      full;
  logic      pop;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign accept    = in_valid && !full;

  dts_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dts_front #(
    .MAX_LEN   (MAX_LEN),
    .MAX_DELIM (MAX_DELIM)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .accept (accept),
    .item   (in_data),
    .push   (push),
    .entry  (entry)
  );

  dts_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (entry),
    .pop   (pop),
    .head  (head),
    .empty (empty),
    .full  (full)
  );

  dts_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### sv/dts_cfg.sv
// Configuration register file of the delimited token splitter.
module dts_cfg import dts_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delimiter_bytes  <= 64'd44;
      cfg.delimiter_length <= 4'd1;
      cfg.keep_empty       <= 1'b0;
      cfg.start_offset     <= 16'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DELIM_BYTES:  cfg.delimiter_bytes  <= cfg_data;
        REG_DELIM_LENGTH: cfg.delimiter_length <= cfg_data[3:0];
        REG_KEEP_EMPTY:   cfg.keep_empty       <= cfg_data[0];
        REG_START_OFFSET: cfg.start_offset     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

### sv/dts_front.sv
// Front end: takes bytes, tracks the delimiter window and token bounds, forms results.
module dts_front import dts_pkg::*; #(
  parameter int MAX_LEN   = MAX_LEN_DEF,
  parameter int MAX_DELIM = MAX_DELIM_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      accept,
  input  in_item_t  item,
  output logic      push,
  output res_pair_t entry
);

  localparam int CNT_RAW_W = $clog2(MAX_LEN + 1);
  localparam int CW        = (CNT_RAW_W > OFS_W) ? CNT_RAW_W : OFS_W;

  logic [CW-1:0] cnt;
  logic [CW-1:0] tb;
  logic          ms;
  logic          ov;
  logic [7:0]    win [MAX_DELIM];

  logic          first;
  logic [CW-1:0] tb_e;
  logic          ms_e;
  logic          ov_e;
  logic [7:0]    win_e [MAX_DELIM];
  logic [7:0]    win_n [MAX_DELIM];
  logic [7:0]    win_next [MAX_DELIM];
  logic [3:0]    len;
  logic          at_limit;
  logic [CW-1:0] cnt_inc;
  logic [CW-1:0] cnt_next;
  logic [CW-1:0] tb_next;
  logic          ms_next;
  logic          ov_next;
  logic [CW-1:0] m;
  logic [MAX_DELIM:1] len_hit;
  logic          win_match;
  logic          hit;
  logic          emit_m;
  logic          any_tok;
  logic          trail;

  always_comb begin
    first = (cnt == '0);
    tb_e  = first ? CW'(cfg.start_offset) : tb;
    ms_e  = first ? 1'b0 : ms;
    ov_e  = first ? 1'b0 : ov;
    for (int k = 0; k < MAX_DELIM; k++) begin
      win_e[k] = first ? 8'h00 : win[k];
    end
    len = (cfg.delimiter_length > 4'(MAX_DELIM)) ? 4'(MAX_DELIM) : cfg.delimiter_length;
    at_limit = (cnt >= CW'(MAX_LEN));
    cnt_inc  = cnt + 1'b1;

    // Shift the new byte in, newest first.
    win_n[0] = item.data_byte;
    for (int k = 1; k < MAX_DELIM; k++) begin
      win_n[k] = win_e[k-1];
    end

    // Compare the window against the delimiter for every possible length.
    for (int l = 1; l <= MAX_DELIM; l++) begin
      len_hit[l] = 1'b1;
      for (int k = 0; k < l; k++) begin
        if (win_n[k] != cfg.delimiter_bytes[8*(l-1-k) +: 8]) len_hit[l] = 1'b0;
      end
    end
    win_match = 1'b0;
    for (int l = 1; l <= MAX_DELIM; l++) begin
      if (len == 4'(l)) win_match = len_hit[l];
    end

    hit = !at_limit && (len != 4'd0) && win_match &&
          ({1'b0, cnt_inc} >= ({1'b0, tb_e} + (CW+1)'(len)));
    m      = cnt_inc - CW'(len);
    emit_m = hit && (cfg.keep_empty || (tb_e < m));

    cnt_next = at_limit ? cnt : cnt_inc;
    for (int k = 0; k < MAX_DELIM; k++) begin
      win_next[k] = at_limit ? win_e[k] : win_n[k];
    end
    tb_next = hit ? cnt_inc : tb_e;
    ms_next = ms_e | hit;
    ov_next = ov_e | at_limit;

    any_tok = (len != 4'd0) && (ms_next || (tb_next < cnt_next));
    trail   = any_tok && (cfg.keep_empty ? (tb_next <= cnt_next) : (tb_next < cnt_next));

    entry.has_match                 = emit_m;
    entry.match_res.token_start     = tb_e[OFS_W-1:0];
    entry.match_res.token_end       = m[OFS_W-1:0];
    entry.match_res.has_token       = 1'b1;
    entry.match_res.too_long        = ov_e;
    entry.match_res.end_of_string   = 1'b0;
    entry.has_final                 = item.last_byte;
    entry.final_res.token_start     = trail ? tb_next[OFS_W-1:0] : '0;
    entry.final_res.token_end       = trail ? cnt_next[OFS_W-1:0] : '0;
    entry.final_res.has_token       = trail;
    entry.final_res.too_long        = ov_next;
    entry.final_res.end_of_string   = 1'b1;

    push = accept && (emit_m || item.last_byte);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      tb  <= '0;
      ms  <= 1'b0;
      ov  <= 1'b0;
    end else if (accept) begin
      if (item.last_byte) begin
        // Drop the string context; the next byte starts a new string.
        cnt <= '0;
        tb  <= '0;
        ms  <= 1'b0;
        ov  <= 1'b0;
      end else begin
        cnt <= cnt_next;
        tb  <= tb_next;
        ms  <= ms_next;
        ov  <= ov_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < MAX_DELIM; k++) begin
        win[k] <= win_next[k];
      end
    end
  end

endmodule

### sv/dts_fifo.sv
// Short queue of result pairs between the front and back ends.
module dts_fifo import dts_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  res_pair_t wdata,
  input  logic      pop,
  output res_pair_t head,
  output logic      empty,
  output logic      full
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  res_pair_t     q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  assign empty = (count == '0);
  assign full  = (count == (PW+1)'(QUEUE_DEPTH));
  assign head  = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### sv/dts_back.sv
// Back end: unpacks queued result pairs to the output register, one per unstalled clock.
module dts_back import dts_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  res_pair_t head,
  input  logic      empty,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic phase;
  logic load;
  logic take;
  logic send_match;

  assign load       = !out_valid || !out_stall;
  assign take       = load && !empty;
  assign send_match = head.has_match && !phase;
  assign pop        = take && !(send_match && head.has_final);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      if (load) out_valid <= take;
      if (take) phase <= send_match && head.has_final;
    end
  end

  always_ff @(posedge clk) begin
    if (take) out_data <= send_match ? head.match_res : head.final_res;
  end

endmodule
